### rtl/core/tlp_pkg.sv
package tlp_pkg;

   // input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] tag;
      logic [9:0]  value_length;
      logic [7:0]  value_byte;
      logic        last_of_element;
      logic        message_done;
   } rsp_type;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // parser phases
   localparam logic [1:0] PHASE_TAG    = 2'd0;
   localparam logic [1:0] PHASE_LENGTH = 2'd1;
   localparam logic [1:0] PHASE_VALUE  = 2'd2;

   // saturation limit of the decimal length
   localparam logic [9:0] LEN_MAX = 10'd999;

   // ascii digit range
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // parser state carried between bytes
   typedef struct packed {
      logic [1:0]  phase;
      logic [1:0]  field_position;
      logic [15:0] tag_shift;
      logic [9:0]  length_accumulator;
      logic        digits_stopped;
      logic [9:0]  bytes_remaining;
   } state_type;

   localparam state_type STATE_RESET = '{PHASE_TAG, 2'd0, 16'd0, 10'd0, 1'b0, 10'd0};

endpackage

### rtl/core/tlp_decode.sv
module tlp_decode
   import tlp_pkg::*;
#(
   parameter int TAG_BYTES    = 2,
   parameter int LENGTH_CHARS = 3
) (
   input  state_type cur_state,
   input  req_type   item,
   output state_type nxt_state,
   output logic      emit,
   output rsp_type   rsp
);

   localparam logic [2:0] TAG_LAST = 3'(TAG_BYTES);
   localparam logic [2:0] LEN_LAST = 3'(LENGTH_CHARS);

   logic [2:0]  pos;
   logic        is_digit;
   logic [13:0] acc_prod;
   logic [9:0]  acc_sat;
   logic [9:0]  remaining;
   logic        truncate;

   assign pos      = {1'b0, cur_state.field_position} + 3'd1;
   assign is_digit = (item.data_byte >= CHAR_ZERO) && (item.data_byte <= CHAR_NINE);
   // acc * 10 + digit, acc never exceeds 999
   assign acc_prod = ({4'd0, cur_state.length_accumulator} << 3)
                   + ({4'd0, cur_state.length_accumulator} << 1)
                   + {10'd0, item.data_byte[3:0]};
   assign acc_sat  = (acc_prod > {4'd0, LEN_MAX}) ? LEN_MAX : acc_prod[9:0];
   assign remaining = cur_state.bytes_remaining - 10'd1;

   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      rsp       = '0;
      truncate  = 1'b0;
      case (cur_state.phase)
         PHASE_LENGTH: begin
            if (!cur_state.digits_stopped && is_digit) begin
               nxt_state.length_accumulator = acc_sat;
            end else begin
               nxt_state.digits_stopped = 1'b1;
            end
            if (pos < LEN_LAST) begin
               nxt_state.field_position = pos[1:0];
               truncate = item.end_of_message;
            end else begin
               nxt_state.field_position = 2'd0;
               if (nxt_state.length_accumulator == 10'd0) begin
                  // zero-length element, header closes it
                  emit                = 1'b1;
                  rsp.kind            = KIND_HEADER;
                  rsp.tag             = cur_state.tag_shift;
                  rsp.last_of_element = 1'b1;
                  rsp.message_done    = item.end_of_message;
                  if (item.end_of_message) begin
                     nxt_state = STATE_RESET;
                  end else begin
                     nxt_state.phase = PHASE_TAG;
                  end
               end else if (item.end_of_message) begin
                  truncate = 1'b1;
               end else begin
                  emit             = 1'b1;
                  rsp.kind         = KIND_HEADER;
                  rsp.tag          = cur_state.tag_shift;
                  rsp.value_length = nxt_state.length_accumulator;
                  nxt_state.bytes_remaining = nxt_state.length_accumulator;
                  nxt_state.phase           = PHASE_VALUE;
               end
            end
         end
         PHASE_VALUE: begin
            nxt_state.bytes_remaining = remaining;
            if (remaining == 10'd0) begin
               emit                = 1'b1;
               rsp.kind            = KIND_VALUE;
               rsp.value_byte      = item.data_byte;
               rsp.last_of_element = 1'b1;
               rsp.message_done    = item.end_of_message;
               if (item.end_of_message) begin
                  nxt_state = STATE_RESET;
               end else begin
                  nxt_state.phase = PHASE_TAG;
               end
            end else if (item.end_of_message) begin
               truncate = 1'b1;
            end else begin
               emit           = 1'b1;
               rsp.kind       = KIND_VALUE;
               rsp.value_byte = item.data_byte;
            end
         end
         default: begin
            // tag phase, unused code lands here too
            nxt_state.phase = PHASE_TAG;
            if (cur_state.field_position == 2'd0) begin
               nxt_state.tag_shift = {8'd0, item.data_byte};
            end else begin
               nxt_state.tag_shift = {cur_state.tag_shift[7:0], item.data_byte};
            end
            if (pos < TAG_LAST) begin
               nxt_state.field_position = pos[1:0];
            end else begin
               nxt_state.field_position     = 2'd0;
               nxt_state.length_accumulator = 10'd0;
               nxt_state.digits_stopped     = 1'b0;
               nxt_state.phase              = PHASE_LENGTH;
            end
            truncate = item.end_of_message;
         end
      endcase
      if (truncate) begin
         nxt_state        = STATE_RESET;
         emit             = 1'b1;
         rsp              = '0;
         rsp.kind         = KIND_ERROR;
         rsp.message_done = 1'b1;
      end
   end

endmodule

### rtl/core/tlv_ascii_length_parser.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_data (req_type)
// rsp_      out        rsp_valid / rsp_stall  rsp_data (rsp_type)
//
// one byte per cycle sustained while results are not stalled; each byte
// passes the input register, then is decoded into the result register
// synchronous active-high reset returns the parser to the tag phase and
// empties both registers; req_stall is held high during reset
// a stalled result blocks the decode step; req_stall rises whenever the input
// register holds a byte while the result is stalled
module tlv_ascii_length_parser
   import tlp_pkg::*;
#(
   parameter int TAG_BYTES    = 2,
   parameter int LENGTH_CHARS = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // input register
   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff, in_data_in;

   // parser state
   state_type state_ff, state_in;

   // result register
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff, out_data_in;

   state_type dec_state;
   logic      dec_emit;
   rsp_type   dec_rsp;

   logic      req_accept;
   logic      out_free;
   logic      advance;

   tlp_decode #(
      .TAG_BYTES    (TAG_BYTES),
      .LENGTH_CHARS (LENGTH_CHARS)
   ) u_decode (
      .cur_state (state_ff),
      .item      (in_data_ff),
      .nxt_state (dec_state),
      .emit      (dec_emit),
      .rsp       (dec_rsp)
   );

   // result slot is free when empty or being taken this cycle
   assign out_free   = !out_valid_ff || !rsp_stall;
   // decode the buffered byte whenever its result has somewhere to go
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = reset || (in_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign state_in = advance ? dec_state : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance && dec_emit) begin
         out_valid_in = 1'b1;
         out_data_in  = dec_rsp;
      end else if (out_free) begin
         // consumed or already empty
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### rtl/core/tlp_checker.sv
module tlp_checker
   import tlp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // an empty result register never backs up the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // a fresh result follows an accepted transaction, through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an accepted transaction");

   // an error result closes the message and carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_ERROR) |->
         rsp_data.message_done && !rsp_data.last_of_element &&
         (rsp_data.tag == 16'd0) && (rsp_data.value_length == 10'd0) &&
         (rsp_data.value_byte == 8'd0))
      else $error("malformed error result");

   // zero-length headers, and only those, close their element
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_HEADER) |->
         (rsp_data.last_of_element == (rsp_data.value_length == 10'd0)))
      else $error("header last flag disagrees with its length");

endmodule

bind tlv_ascii_length_parser tlp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
